### src/usv_pkg.sv
// shared types, constants and helpers for the uv sphere vertex generator
// no dependencies
`default_nettype none
package usv_pkg;

    localparam int IDX_W   = 9;
    localparam int DIV_W   = 9;
    localparam int NUM_W   = IDX_W + 32 + 1;
    localparam int ANG_W   = 32;
    localparam int CX_W    = 34;
    localparam int CZ_W    = 33;
    localparam int TRIG_W  = 32;
    localparam int RAD_W   = 16;
    localparam int COORD_W = 17;
    localparam int TEX_W   = 17;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 88;
    localparam int ATAN_LEN = 24;

    localparam int DEF_MAX_DIVISIONS = 256;
    localparam int DEF_CORDIC_STEPS  = 16;

    localparam logic [CFG_A_W-1:0] REG_SECTOR_COUNT = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_STACK_COUNT  = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic signed [CX_W-1:0]   CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CX_W-1:0]   ONE_Q30     = 34'sd1073741824;
    localparam logic signed [23:0]       COORD_LIMIT = 24'sd65535;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

    function automatic logic [ANG_W-1:0] atan_turn(input int k);
        logic [ANG_W-1:0] v;
        case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CX_W-1:0] v);
        logic signed [CX_W-1:0] r;
        if (v > ONE_Q30) r = ONE_Q30;
        else if (v < -ONE_Q30) r = -ONE_Q30;
        else r = v;
        return r[TRIG_W-1:0];
    endfunction

    function automatic trig_t quad_rot(input logic [1:0] q,
                                       input logic signed [CX_W-1:0] x,
                                       input logic signed [CX_W-1:0] y);
        trig_t t;
        case (q)
            2'd0: begin
                t.c = clamp_unit(x);
                t.s = clamp_unit(y);
            end
            2'd1: begin
                t.c = clamp_unit(-y);
                t.s = clamp_unit(x);
            end
            2'd2: begin
                t.c = clamp_unit(-x);
                t.s = clamp_unit(-y);
            end
            default: begin
                t.c = clamp_unit(y);
                t.s = clamp_unit(-x);
            end
        endcase
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [23:0] v);
        logic signed [23:0] r;
        if (v > COORD_LIMIT) r = COORD_LIMIT;
        else if (v < -COORD_LIMIT) r = -COORD_LIMIT;
        else r = v;
        return r[COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/usv_div_cell.sv
// one restoring division step: consumes a numerator bit, produces a quotient bit
// depends on usv_pkg
`default_nettype none
module usv_div_cell (
    input  wire                        aclk,
    input  wire                        en,
    input  wire [usv_pkg::DIV_W-1:0]   d,
    input  wire [usv_pkg::DIV_W-1:0]   rem_i,
    input  wire [usv_pkg::NUM_W-1:0]   word_i,
    output logic [usv_pkg::DIV_W-1:0]  rem_o,
    output logic [usv_pkg::NUM_W-1:0]  word_o
);
    import usv_pkg::*;

    logic [DIV_W:0]   t;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [NUM_W-1:0] word_next;
    logic [DIV_W-1:0] rem_reg;
    logic [NUM_W-1:0] word_reg;

    always_comb begin
        t         = {rem_i, word_i[NUM_W-1]};
        diff      = t - {1'b0, d};
        ge        = (t >= {1'b0, d});
        rem_next  = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
        word_next = {word_i[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign rem_o  = rem_reg;
    assign word_o = word_reg;
endmodule
`default_nettype wire

### src/usv_cordic_cell.sv
// one cordic micro-rotation with a fixed shift, quadrant passed along
// depends on usv_pkg
`default_nettype none
module usv_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                              aclk,
    input  wire                              en,
    input  wire signed [usv_pkg::CX_W-1:0]   x_i,
    input  wire signed [usv_pkg::CX_W-1:0]   y_i,
    input  wire signed [usv_pkg::CZ_W-1:0]   z_i,
    input  wire [1:0]                        q_i,
    output logic signed [usv_pkg::CX_W-1:0]  x_o,
    output logic signed [usv_pkg::CX_W-1:0]  y_o,
    output logic signed [usv_pkg::CZ_W-1:0]  z_o,
    output logic [1:0]                       q_o
);
    import usv_pkg::*;

    localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_turn(STEP));

    logic signed [CX_W-1:0] dx, dy, x_next, y_next, x_reg, y_reg;
    logic signed [CZ_W-1:0] z_next, z_reg;
    logic [1:0]             q_reg;

    always_comb begin
        dx = y_i >>> STEP;
        dy = x_i >>> STEP;
        if (!z_i[CZ_W-1]) begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ATAN;
        end else begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            q_reg <= q_i;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;
    assign q_o = q_reg;
endmodule
`default_nettype wire

### src/usv_coord.sv
// radius scaling of the trig values into rounded, saturated vertex coordinates
// four register stages; depends on usv_pkg
`default_nettype none
module usv_coord (
    input  wire                                aclk,
    input  wire                                en,
    input  wire [usv_pkg::RAD_W-1:0]           radius,
    input  usv_pkg::trig_t                     elev,
    input  usv_pkg::trig_t                     azim,
    output logic signed [usv_pkg::COORD_W-1:0] pos_x,
    output logic signed [usv_pkg::COORD_W-1:0] pos_y,
    output logic signed [usv_pkg::COORD_W-1:0] pos_z
);
    import usv_pkg::*;

    localparam logic signed [48:0] RND13 = 49'sd1 <<< 13;
    localparam logic signed [48:0] RND29 = 49'sd1 <<< 29;
    localparam logic signed [66:0] RND45 = 67'sd1 <<< 45;

    logic signed [RAD_W:0]   r_s;
    logic signed [48:0]      py_prod_reg, xy_prod_reg;
    trig_t                   az_a_reg, az_b_reg;
    logic signed [34:0]      xy_reg;
    logic signed [COORD_W-1:0] py_b_reg, py_c_reg;
    logic signed [66:0]      px_prod_reg, pz_prod_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;

    assign r_s = $signed({1'b0, radius});

    always_ff @(posedge aclk) begin
        if (en) begin
            py_prod_reg <= r_s * elev.s;
            xy_prod_reg <= r_s * elev.c;
            az_a_reg    <= azim;
            xy_reg      <= 35'((xy_prod_reg + RND13) >>> 14);
            py_b_reg    <= sat_coord(24'((py_prod_reg + RND29) >>> 30));
            az_b_reg    <= az_a_reg;
            px_prod_reg <= xy_reg * az_b_reg.c;
            pz_prod_reg <= xy_reg * az_b_reg.s;
            py_c_reg    <= py_b_reg;
            px_reg      <= sat_coord(24'((px_prod_reg + RND45) >>> 46));
            pz_reg      <= sat_coord(24'((pz_prod_reg + RND45) >>> 46));
            py_reg      <= py_c_reg;
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;
endmodule
`default_nettype wire

### src/uv_sphere_vertex_generator.sv
// uv sphere vertex generator: from input transfer to output valid a vertex passes one
// capture stage, 42 divider cells, angle prep, the cordic cells, quadrant rotation
// and four multiply/round stages
// throughput one vertex per cycle; the whole pipeline holds while the output waits
// synchronous active-low reset restores the counts and radius and empties the pipeline
// depends on usv_pkg, usv_div_cell, usv_cordic_cell, usv_coord
`default_nettype none
module uv_sphere_vertex_generator #(
    parameter int MAX_DIVISIONS = usv_pkg::DEF_MAX_DIVISIONS,
    parameter int CORDIC_STEPS  = usv_pkg::DEF_CORDIC_STEPS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire [usv_pkg::CFG_A_W-1:0]        cfg_addr,
    input  wire [usv_pkg::CFG_D_W-1:0]        cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // stack_index, sector_index
    input  wire [usv_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic [usv_pkg::M_DATA_W-1:0]      m_tdata
);
    import usv_pkg::*;

    localparam int TEX_DLY = CORDIC_STEPS + 5;
    localparam int LAT     = 1 + NUM_W + 1 + TEX_DLY;

    logic [IDX_W-1:0] sector_count_reg, stack_count_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [IDX_W-1:0] s_eff, t_eff;
    logic [IDX_W-1:0] in_i, in_j, i_reg, j_reg;
    logic             adv;
    logic [LAT-1:0]   vld_reg, vld_next;

    function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] c,
                                                     input int lo);
        logic [IDX_W-1:0] r;
        if (int'(c) < lo) r = IDX_W'(lo);
        else if (int'(c) > MAX_DIVISIONS) r = IDX_W'(MAX_DIVISIONS);
        else r = c;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg <= 9'd36;
            stack_count_reg  <= 9'd18;
            radius_reg       <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SECTOR_COUNT: sector_count_reg <= cfg_wdata[IDX_W-1:0];
                REG_STACK_COUNT:  stack_count_reg  <= cfg_wdata[IDX_W-1:0];
                REG_RADIUS:       radius_reg       <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_eff    = clamp_count(sector_count_reg, 3);
    assign t_eff    = clamp_count(stack_count_reg, 2);
    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        in_i = s_tdata[IDX_W-1:0];
        in_j = s_tdata[2*IDX_W-1:IDX_W];
        if (in_i > t_eff) in_i = t_eff;
        if (in_j > s_eff) in_j = s_eff;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i_reg <= in_i;
            j_reg <= in_j;
        end
    end

    // divider lanes: azimuth, elevation, tex u, tex v
    logic [NUM_W-1:0] dw [4][NUM_W+1];
    logic [DIV_W-1:0] dr [4][NUM_W+1];
    logic [DIV_W-1:0] dd [4];

    assign dd[0] = s_eff;
    assign dd[1] = t_eff;
    assign dd[2] = s_eff;
    assign dd[3] = t_eff;
    assign dw[0][0] = NUM_W'({j_reg, 32'b0}) + NUM_W'(s_eff >> 1);
    assign dw[1][0] = NUM_W'({i_reg, 31'b0}) + NUM_W'(t_eff >> 1);
    assign dw[2][0] = NUM_W'({j_reg, 16'b0}) + NUM_W'(s_eff >> 1);
    assign dw[3][0] = NUM_W'({i_reg, 16'b0}) + NUM_W'(t_eff >> 1);

    genvar l, k;
    generate
        for (l = 0; l < 4; l++) begin : g_div_lane
            assign dr[l][0] = '0;
            for (k = 0; k < NUM_W; k++) begin : g_div_cell
                usv_div_cell u_cell (
                    .aclk   (aclk),
                    .en     (adv),
                    .d      (dd[l]),
                    .rem_i  (dr[l][k]),
                    .word_i (dw[l][k]),
                    .rem_o  (dr[l][k+1]),
                    .word_o (dw[l][k+1])
                );
            end
        end
    endgenerate

    // angle prep: quadrant and signed residual, lane 0 elevation, lane 1 azimuth
    logic [ANG_W-1:0] ang [2];
    logic [ANG_W-1:0] ang_sum [2];
    logic [ANG_W-1:0] ang_res [2];
    logic signed [CX_W-1:0] cx [2][CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy [2][CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] cz [2][CORDIC_STEPS+1];
    logic [1:0]             cq [2][CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] z0_reg [2];
    logic [1:0]             q0_reg [2];
    logic [TEX_W-1:0]       tu_reg [TEX_DLY+1];
    logic [TEX_W-1:0]       tv_reg [TEX_DLY+1];

    assign ang[0] = 32'h4000_0000 - dw[1][NUM_W][ANG_W-1:0];
    assign ang[1] = dw[0][NUM_W][ANG_W-1:0];

    generate
        for (l = 0; l < 2; l++) begin : g_prep
            assign ang_sum[l] = ang[l] + 32'h2000_0000;
            assign ang_res[l] = ang[l] - {ang_sum[l][31:30], 30'b0};
            always_ff @(posedge aclk) begin
                if (adv) begin
                    z0_reg[l] <= $signed({ang_res[l][ANG_W-1], ang_res[l]});
                    q0_reg[l] <= ang_sum[l][31:30];
                end
            end
            assign cx[l][0] = CORDIC_GAIN;
            assign cy[l][0] = '0;
            assign cz[l][0] = z0_reg[l];
            assign cq[l][0] = q0_reg[l];
            for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
                usv_cordic_cell #(.STEP(k)) u_cell (
                    .aclk (aclk),
                    .en   (adv),
                    .x_i  (cx[l][k]),
                    .y_i  (cy[l][k]),
                    .z_i  (cz[l][k]),
                    .q_i  (cq[l][k]),
                    .x_o  (cx[l][k+1]),
                    .y_o  (cy[l][k+1]),
                    .z_o  (cz[l][k+1]),
                    .q_o  (cq[l][k+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv) begin
            tu_reg[0] <= dw[2][NUM_W][TEX_W-1:0];
            tv_reg[0] <= dw[3][NUM_W][TEX_W-1:0];
            for (int n = 1; n <= TEX_DLY; n++) begin
                tu_reg[n] <= tu_reg[n-1];
                tv_reg[n] <= tv_reg[n-1];
            end
        end
    end

    trig_t elev_reg, azim_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            elev_reg <= quad_rot(cq[0][CORDIC_STEPS], cx[0][CORDIC_STEPS],
                                 cy[0][CORDIC_STEPS]);
            azim_reg <= quad_rot(cq[1][CORDIC_STEPS], cx[1][CORDIC_STEPS],
                                 cy[1][CORDIC_STEPS]);
        end
    end

    logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;

    usv_coord u_coord (
        .aclk   (aclk),
        .en     (adv),
        .radius (radius_reg),
        .elev   (elev_reg),
        .azim   (azim_reg),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {3'b0, tv_reg[TEX_DLY], tu_reg[TEX_DLY], pos_z, pos_y, pos_x};

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_tex_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:51] <= 17'd65536))
        else $error("tex_u above one");

    a_tex_v_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[84:68] <= 17'd65536))
        else $error("tex_v above one");

    a_pos_x_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:0] != 17'h10000))
        else $error("pos_x outside saturation range");
endmodule
`default_nettype wire

### tb/sv/tb_uv_sphere_vertex_generator.sv
// testbench for the uv sphere vertex generator: streams grid points, predicts each vertex
// with a cordic-based model of its own and compares every output transfer field by field
// depends on usv_pkg and uv_sphere_vertex_generator
`default_nettype none
module tb_uv_sphere_vertex_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import usv_pkg::*;

    localparam int MAXDIV = 256;
    localparam int STEPS  = 16;
    localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [16:0] tv;
        logic [16:0] tu;
        logic [16:0] pz;
        logic [16:0] py;
        logic [16:0] px;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_D_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    uv_sphere_vertex_generator dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [8:0] sectors = 9'd36;
    logic [8:0] stacks = 9'd18;
    logic [15:0] radius = 16'd256;
    vertex_t vertex_q[$];
    int errors = 0;
    int hold_cycles = 0;
    bit sink_busy = 1'b0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint atan_turn_tb(int k);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
            20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return t[k];
    endfunction

    function automatic void sincos(logic [31:0] ang, output longint c, output longint s);
        logic [31:0] q, rem;
        longint z, x, y, dx, dy;
        q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        rem = ang - (q << 30);
        z = rem[31] ? longint'(rem) - 64'sd4294967296 : longint'(rem);
        x = 652032874;
        y = 0;
        for (int k = 0; k < STEPS && k < ATAN_LEN; k++) begin
            dx = asr(y, k);
            dy = asr(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn_tb(k));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn_tb(k));
            end
        end
        case (q)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c = clamp(c, -(64'sd1 << 30), 64'sd1 << 30);
        s = clamp(s, -(64'sd1 << 30), 64'sd1 << 30);
    endfunction

    function automatic vertex_t predict_vertex(logic [8:0] si, logic [8:0] sj);
        longint unsigned S, T, i, j;
        logic [31:0] az, el;
        longint ce, se, ca, sa, xy, r;
        vertex_t v;
        S = clamp(sectors, 3, MAXDIV);
        T = clamp(stacks, 2, MAXDIV);
        i = si;
        j = sj;
        if (i > T) i = T;
        if (j > S) j = S;
        az = 32'(((j << 32) + S / 2) / S);
        el = 32'h4000_0000 - 32'(((i << 31) + T / 2) / T);
        sincos(el, ce, se);
        sincos(az, ca, sa);
        r = radius;
        v.py = 17'(clamp(asr(r * se + (64'sd1 << 29), 30), -65535, 65535));
        xy = asr(r * ce + (64'sd1 << 13), 14);
        v.px = 17'(clamp(asr(xy * ca + (64'sd1 << 45), 46), -65535, 65535));
        v.pz = 17'(clamp(asr(xy * sa + (64'sd1 << 45), 46), -65535, 65535));
        v.tu = 17'((j * 65536 + S / 2) / S);
        v.tv = 17'((i * 65536 + T / 2) / T);
        return v;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SECTOR_COUNT: sectors = val[8:0];
            REG_STACK_COUNT: stacks = val[8:0];
            REG_RADIUS: radius = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_point(logic [8:0] si, logic [8:0] sj, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, sj, si};
        do @(posedge aclk); while (!s_tready);
        vertex_q = {vertex_q, predict_vertex(si, sj)};
    endtask

    task automatic set_mesh(logic [8:0] s, logic [8:0] t, logic [15:0] r);
        wait_drained();
        write_reg(REG_SECTOR_COUNT, 16'(s));
        write_reg(REG_STACK_COUNT, 16'(t));
        write_reg(REG_RADIUS, r);
    endtask

    task automatic test_directed();
        send_point(9'd0, 9'd0, 0);
        send_point(9'd18, 9'd36, 0);
        send_point(9'd9, 9'd9, 0);
        send_point(9'd511, 9'd511, 0);
        send_point(9'd300, 9'd17, 0);
        set_mesh(9'd0, 9'd0, 16'hffff);
        for (int k = 0; k < 4; k++) send_point(9'(k), 9'(k), 0);
        set_mesh(9'd511, 9'd511, 16'd0);
        send_point(9'd255, 9'd256, 0);
        send_point(9'd128, 9'd64, 0);
        set_mesh(9'd256, 9'd256, 16'hffff);
        send_point(9'd256, 9'd256, 0);
        send_point(9'd128, 9'd192, 0);
        send_point(9'd1, 9'd255, 0);
        set_mesh(9'd3, 9'd2, 16'h8000);
        for (int k = 0; k < 4; k++) send_point(9'd1, 9'(k), 0);
        wait_drained();
        write_reg(REG_UNUSED, 16'h1234);
        send_point(9'd1, 9'd1, 0);
    endtask

    task automatic test_random_grid();
        logic [8:0] s, t, si, sj;
        for (int ph = 0; ph < 8; ph++) begin
            s = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(3, 40));
            t = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(2, 40));
            set_mesh(s, t, 16'($urandom));
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    si = 9'($urandom);
                    sj = 9'($urandom);
                end else begin
                    si = 9'($urandom_range(0, 256));
                    sj = 9'($urandom_range(0, 256));
                end
                send_point(si, sj, 1);
            end
        end
    endtask

    task automatic test_backpressure();
        set_mesh(9'd36, 9'd18, 16'd256);
        hold_cycles = 300;
        for (int n = 0; n < 120; n++) send_point(9'($urandom), 9'($urandom), 0);
        wait_drained();
        for (int n = 0; n < 20; n++) send_point(9'($urandom), 9'($urandom), 1);
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        vertex_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = vertex_t'(m_tdata[84:0]);
            if (vertex_q.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, m_tdata);
                errors++;
            end else begin
                want = vertex_q.pop_front();
                if (got.px !== want.px)
                    $display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
                if (got.py !== want.py)
                    $display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
                if (got.pz !== want.pz)
                    $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz);
                if (got.tu !== want.tu)
                    $display("%0t: tex_u exp %h got %h", $time, want.tu, got.tu);
                if (got.tv !== want.tv)
                    $display("%0t: tex_v exp %h got %h", $time, want.tv, got.tv);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_grid();
        wait_drained();
        if (errors == 0 && vertex_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
